>>> hdl/cidp_pkg.sv
// ----------------------------------------------------------------------------
// cidp_pkg
// Types and constants shared by the caller-ID frame parser.
// ----------------------------------------------------------------------------
package cidp_pkg;

	localparam int unsigned QDEPTH   = 4;
	localparam int unsigned QPTR_W   = $clog2(QDEPTH);
	localparam int unsigned QCNT_W   = $clog2(QDEPTH + 1);
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned POS_W    = 9;
	localparam logic [7:0]  DATE_LEN = 8'd8;
	localparam logic [7:0]  CHAR_P   = 8'h50;
	localparam logic [7:0]  CHAR_O   = 8'h4F;

	localparam logic [CFG_IDX_W-1:0] REG_SINGLE_FMT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MULTI_FMT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DATETIME   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NUMBER     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ABSENT     = 3'd4;

	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_DATA   = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_SUM  = 2'd1;
	localparam logic [1:0] ST_BAD_TYPE = 2'd2;

	localparam logic [0:0] CMD_BYTE    = 1'b0;
	localparam logic [0:0] CMD_RESTART = 1'b1;

	typedef enum logic [3:0] {
		MK_NONE    = 4'b0001,
		MK_SINGLE  = 4'b0010,
		MK_MULTI   = 4'b0100,
		MK_UNKNOWN = 4'b1000
	} msg_kind_t;

	typedef enum logic [2:0] {
		PH_TYPE = 3'b001,
		PH_LEN  = 3'b010,
		PH_DATA = 3'b100
	} rec_phase_t;

	typedef struct packed {
		logic [7:0] single_format_code;
		logic [7:0] multi_format_code;
		logic [7:0] datetime_record_code;
		logic [7:0] number_record_code;
		logic [7:0] absent_record_code;
	} cfg_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] param_type;
		logic [7:0] record_length;
		logic [7:0] data_byte;
		logic       last_in_record;
		logic [1:0] frame_status;
		logic       last;
	} result_t;

endpackage

>>> hdl/cidp_if.sv
// ----------------------------------------------------------------------------
// cidp channel interfaces
// Valid/ready channels for received bytes, results and register writes.
// ----------------------------------------------------------------------------
interface cidp_in_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] rx_byte;
	modport source (output valid, cmd, rx_byte, input ready);
	modport sink   (input valid, cmd, rx_byte, output ready);
endinterface

interface cidp_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] param_type;
	logic [7:0] record_length;
	logic [7:0] data_byte;
	logic       last_in_record;
	logic [1:0] frame_status;
	logic       last;
	modport source (output valid, kind, param_type, record_length, data_byte,
		last_in_record, frame_status, last, input ready);
	modport sink   (input valid, kind, param_type, record_length, data_byte,
		last_in_record, frame_status, last, output ready);
endinterface

interface cidp_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [cidp_pkg::CFG_IDX_W-1:0] reg_index;
	logic [7:0]                     wr_data;
	modport source (output valid, reg_index, wr_data, input ready);
	modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

>>> hdl/cidp_parser.sv
// ----------------------------------------------------------------------------
// cidp_parser
// Frame state and per-byte result generation: up to two results per item.
// ----------------------------------------------------------------------------
module cidp_parser (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accept,
	input  logic                           cmd,
	input  logic [7:0]                     rx_byte,
	input  cidp_pkg::cfg_t                 cfg,
	output logic [1:0]                     push_cnt,
	output cidp_pkg::result_t              res0,
	output cidp_pkg::result_t              res1
);

	logic [cidp_pkg::POS_W-1:0] frame_pos_q, frame_pos_d;
	logic [7:0]                 payload_len_q, payload_len_d;
	cidp_pkg::msg_kind_t        msg_kind_q, msg_kind_d;
	logic [7:0]                 running_sum_q, running_sum_d;
	cidp_pkg::rec_phase_t       rec_phase_q, rec_phase_d;
	logic [7:0]                 rec_type_q, rec_type_d;
	logic [7:0]                 rec_remaining_q, rec_remaining_d;
	logic                       frame_done_q, frame_done_d;

	logic [cidp_pkg::POS_W-1:0] p;
	logic                       in_payload;
	logic                       flast;
	logic [7:0]                 sum_new;
	logic [7:0]                 rem_new;
	logic                       lir;
	cidp_pkg::result_t          hdr, dat, sts;

	assign p          = frame_pos_q - cidp_pkg::POS_W'(2);
	assign in_payload = (frame_pos_q >= cidp_pkg::POS_W'(2)) &&
		(p < {1'b0, payload_len_q});
	assign flast      = ((p + cidp_pkg::POS_W'(1)) == {1'b0, payload_len_q});
	assign sum_new    = running_sum_q + rx_byte;

	always_comb begin
		frame_pos_d     = frame_pos_q;
		payload_len_d   = payload_len_q;
		msg_kind_d      = msg_kind_q;
		running_sum_d   = running_sum_q;
		rec_phase_d     = rec_phase_q;
		rec_type_d      = rec_type_q;
		rec_remaining_d = rec_remaining_q;
		frame_done_d    = frame_done_q;
		push_cnt        = 2'd0;
		rem_new         = 8'd0;
		lir             = 1'b0;
		hdr             = '0;
		dat             = '0;
		sts             = '0;
		res0            = '0;
		res1            = '0;

		if (cmd == cidp_pkg::CMD_RESTART) begin
			frame_pos_d     = '0;
			payload_len_d   = '0;
			msg_kind_d      = cidp_pkg::MK_NONE;
			running_sum_d   = '0;
			rec_phase_d     = cidp_pkg::PH_TYPE;
			rec_type_d      = '0;
			rec_remaining_d = '0;
			frame_done_d    = 1'b0;
		end else if (!frame_done_q) begin
			running_sum_d = sum_new;
			if (frame_pos_q == '0) begin
				if (rx_byte == cfg.single_format_code)
					msg_kind_d = cidp_pkg::MK_SINGLE;
				else if (rx_byte == cfg.multi_format_code)
					msg_kind_d = cidp_pkg::MK_MULTI;
				else
					msg_kind_d = cidp_pkg::MK_UNKNOWN;
				frame_pos_d = cidp_pkg::POS_W'(1);
			end else if (frame_pos_q == cidp_pkg::POS_W'(1)) begin
				payload_len_d = rx_byte;
				frame_pos_d   = cidp_pkg::POS_W'(2);
			end else if (in_payload) begin
				frame_pos_d = frame_pos_q + cidp_pkg::POS_W'(1);
				case (msg_kind_q)
					cidp_pkg::MK_SINGLE: begin
						if (rec_remaining_q == '0) begin
							if (p == '0) begin
								rec_type_d = cfg.datetime_record_code;
								rem_new    = cidp_pkg::DATE_LEN;
							end else if (rx_byte == cidp_pkg::CHAR_P ||
								rx_byte == cidp_pkg::CHAR_O) begin
								rec_type_d = cfg.absent_record_code;
								rem_new    = 8'd1;
							end else begin
								rec_type_d = cfg.number_record_code;
								rem_new    = payload_len_q - cidp_pkg::DATE_LEN;
							end
							hdr.kind          = cidp_pkg::KIND_HEADER;
							hdr.param_type    = rec_type_d;
							hdr.record_length = rem_new;
						end else begin
							rem_new = rec_remaining_q;
						end
						rec_remaining_d    = rem_new - 8'd1;
						lir                = (rec_remaining_d == '0) || flast;
						dat.kind           = cidp_pkg::KIND_DATA;
						dat.param_type     = rec_type_d;
						dat.data_byte      = rx_byte;
						dat.last_in_record = lir;
						dat.last           = 1'b1;
						if (rec_remaining_q == '0) begin
							res0     = hdr;
							res1     = dat;
							push_cnt = 2'd2;
						end else begin
							res0     = dat;
							push_cnt = 2'd1;
						end
					end
					cidp_pkg::MK_MULTI: begin
						case (rec_phase_q)
							cidp_pkg::PH_TYPE: begin
								rec_type_d  = rx_byte;
								rec_phase_d = cidp_pkg::PH_LEN;
							end
							cidp_pkg::PH_LEN: begin
								rec_remaining_d   = rx_byte;
								hdr.kind          = cidp_pkg::KIND_HEADER;
								hdr.param_type    = rec_type_q;
								hdr.record_length = rx_byte;
								hdr.last          = 1'b1;
								res0              = hdr;
								push_cnt          = 2'd1;
								rec_phase_d = (rx_byte == '0) ? cidp_pkg::PH_TYPE
									: cidp_pkg::PH_DATA;
							end
							default: begin
								rec_remaining_d    = rec_remaining_q - 8'd1;
								dat.kind           = cidp_pkg::KIND_DATA;
								dat.param_type     = rec_type_q;
								dat.data_byte      = rx_byte;
								dat.last_in_record = (rec_remaining_d == '0) || flast;
								dat.last           = 1'b1;
								res0               = dat;
								push_cnt           = 2'd1;
								if (rec_remaining_d == '0)
									rec_phase_d = cidp_pkg::PH_TYPE;
							end
						endcase
					end
					default: ;
				endcase
			end else begin
				sts.kind = cidp_pkg::KIND_STATUS;
				if (msg_kind_q == cidp_pkg::MK_UNKNOWN || msg_kind_q == cidp_pkg::MK_NONE)
					sts.frame_status = cidp_pkg::ST_BAD_TYPE;
				else if (sum_new != '0)
					sts.frame_status = cidp_pkg::ST_BAD_SUM;
				else
					sts.frame_status = cidp_pkg::ST_OK;
				sts.last     = 1'b1;
				res0         = sts;
				push_cnt     = 2'd1;
				frame_done_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_pos_q     <= '0;
			payload_len_q   <= '0;
			msg_kind_q      <= cidp_pkg::MK_NONE;
			running_sum_q   <= '0;
			rec_phase_q     <= cidp_pkg::PH_TYPE;
			rec_type_q      <= '0;
			rec_remaining_q <= '0;
			frame_done_q    <= 1'b0;
		end else if (accept) begin
			frame_pos_q     <= frame_pos_d;
			payload_len_q   <= payload_len_d;
			msg_kind_q      <= msg_kind_d;
			running_sum_q   <= running_sum_d;
			rec_phase_q     <= rec_phase_d;
			rec_type_q      <= rec_type_d;
			rec_remaining_q <= rec_remaining_d;
			frame_done_q    <= frame_done_d;
		end
	end

endmodule

>>> hdl/cidp_outq.sv
// ----------------------------------------------------------------------------
// cidp_outq
// Small result queue: takes up to two results a cycle, hands out one.
// ----------------------------------------------------------------------------
module cidp_outq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [1:0]                    push_cnt,
	input  cidp_pkg::result_t             push0,
	input  cidp_pkg::result_t             push1,
	input  logic                          pop,
	output logic                          has_room,
	output logic                          not_empty,
	output cidp_pkg::result_t             head
);

	cidp_pkg::result_t                 mem_q [cidp_pkg::QDEPTH];
	logic [cidp_pkg::QPTR_W-1:0]       wr_ptr_q, rd_ptr_q;
	logic [cidp_pkg::QCNT_W-1:0]       count_q;
	logic [cidp_pkg::QPTR_W-1:0]       wr_ptr1;
	logic                              do_pop;

	assign wr_ptr1   = wr_ptr_q + cidp_pkg::QPTR_W'(1);
	assign not_empty = (count_q != '0);
	assign has_room  = (count_q <= cidp_pkg::QCNT_W'(cidp_pkg::QDEPTH - 2));
	assign head      = mem_q[rd_ptr_q];
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0)
			mem_q[wr_ptr_q] <= push0;
		if (push_cnt == 2'd2)
			mem_q[wr_ptr1] <= push1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + cidp_pkg::QPTR_W'(push_cnt);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + cidp_pkg::QPTR_W'(1);
			count_q <= count_q + cidp_pkg::QCNT_W'(push_cnt)
				- cidp_pkg::QCNT_W'(do_pop);
		end
	end

endmodule

>>> hdl/caller_id_frame_parser_top.sv
// ----------------------------------------------------------------------------
// caller_id_frame_parser_top
// Caller-ID message parser for single and multiple data message formats.
// ----------------------------------------------------------------------------
// Usage:
//   rx  : one item per demodulated byte (cmd = 0) or a restart (cmd = 1).
//   res : record headers, record data bytes and the frame status, in order;
//         last marks the final result caused by one rx item.
//   cfg : register writes (format codes and reported record types), always
//         ready; write only while the block is idle.
// Each rx item is parsed in the cycle it is accepted and its zero, one or
// two results are written into a four-entry result queue that drives res.
// rx accepts one item per cycle while the queue has room for two results,
// so a byte that yields a header and a data byte takes two transfers on
// the single res port; sustained rate is one item per cycle for one-result
// bytes while res is ready, set by the one-result-per-cycle res port. When
// res stalls, the queue fills and rx.ready drops; nothing is lost.
// Reset clears the frame state and the queue and loads the default codes.
// ----------------------------------------------------------------------------
module caller_id_frame_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	cidp_cfg_if.sink    cfg,
	cidp_in_if.sink     rx,
	cidp_out_if.source  res
);

	cidp_pkg::cfg_t    cfg_q;
	cidp_pkg::result_t res0, res1, head;
	logic [1:0]        push_cnt;
	logic              has_room, not_empty, accept;

	assign cfg.ready = 1'b1;
	assign rx.ready  = has_room;
	assign accept    = rx.valid && has_room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.single_format_code   <= 8'd4;
			cfg_q.multi_format_code    <= 8'd128;
			cfg_q.datetime_record_code <= 8'd1;
			cfg_q.number_record_code   <= 8'd2;
			cfg_q.absent_record_code   <= 8'd4;
		end else if (cfg.valid) begin
			case (cfg.reg_index)
				cidp_pkg::REG_SINGLE_FMT: cfg_q.single_format_code   <= cfg.wr_data;
				cidp_pkg::REG_MULTI_FMT:  cfg_q.multi_format_code    <= cfg.wr_data;
				cidp_pkg::REG_DATETIME:   cfg_q.datetime_record_code <= cfg.wr_data;
				cidp_pkg::REG_NUMBER:     cfg_q.number_record_code   <= cfg.wr_data;
				cidp_pkg::REG_ABSENT:     cfg_q.absent_record_code   <= cfg.wr_data;
				default: ;
			endcase
		end
	end

	cidp_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.cmd      (rx.cmd),
		.rx_byte  (rx.rx_byte),
		.cfg      (cfg_q),
		.push_cnt (push_cnt),
		.res0     (res0),
		.res1     (res1)
	);

	cidp_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cnt  (accept ? push_cnt : 2'd0),
		.push0     (res0),
		.push1     (res1),
		.pop       (res.ready),
		.has_room  (has_room),
		.not_empty (not_empty),
		.head      (head)
	);

	assign res.valid          = not_empty;
	assign res.kind           = head.kind;
	assign res.param_type     = head.param_type;
	assign res.record_length  = head.record_length;
	assign res.data_byte      = head.data_byte;
	assign res.last_in_record = head.last_in_record;
	assign res.frame_status   = head.frame_status;
	assign res.last           = head.last;

endmodule

>>> tb/caller_id_frame_parser_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// caller_id_frame_parser_top_test
// Self-checking bench for the caller-ID frame parser. A tracker class keeps
// its own copy of the frame state and register file, predicts the headers,
// data bytes and status for every accepted item, and matches each result in
// order. Stimulus: a few directed frames, then random single-format,
// multi-format and unknown frames under six register settings, with sender
// bursts, receiver stalls and a long receiver hold-off.
// ----------------------------------------------------------------------------
module caller_id_frame_parser_top_test;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASES       = 6;
	localparam int PHASE_ITEMS  = 340;

	typedef struct packed {
		bit       cmd;
		bit [7:0] val;
	} rx_item_t;

	class cid_parse_tracker;
		cidp_pkg::cfg_t       regs;
		bit [8:0]             pos;
		bit [7:0]             plen;
		cidp_pkg::msg_kind_t  mkind;
		bit [7:0]             sum;
		cidp_pkg::rec_phase_t phase;
		bit [7:0]             rtype;
		bit [7:0]             rleft;
		bit                   done;
		cidp_pkg::result_t    owed_results[$];
		int                   errors;
		int                   parsed;
		int                   matched;

		function new();
			regs.single_format_code   = 8'd4;
			regs.multi_format_code    = 8'd128;
			regs.datetime_record_code = 8'd1;
			regs.number_record_code   = 8'd2;
			regs.absent_record_code   = 8'd4;
			errors  = 0;
			parsed  = 0;
			matched = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			pos   = '0;
			plen  = '0;
			mkind = cidp_pkg::MK_NONE;
			sum   = '0;
			phase = cidp_pkg::PH_TYPE;
			rtype = '0;
			rleft = '0;
			done  = 1'b0;
		endfunction

		function void set_reg(bit [cidp_pkg::CFG_IDX_W-1:0] idx, bit [7:0] v);
			case (idx)
				cidp_pkg::REG_SINGLE_FMT: regs.single_format_code   = v;
				cidp_pkg::REG_MULTI_FMT:  regs.multi_format_code    = v;
				cidp_pkg::REG_DATETIME:   regs.datetime_record_code = v;
				cidp_pkg::REG_NUMBER:     regs.number_record_code   = v;
				cidp_pkg::REG_ABSENT:     regs.absent_record_code   = v;
				default: ;
			endcase
		endfunction

		function int pending();
			return owed_results.size();
		endfunction

		function void owe(logic [1:0] kind, bit [7:0] ptype, bit [7:0] rlen,
			bit [7:0] dbyte, bit lir, logic [1:0] st);
			cidp_pkg::result_t r;
			r.kind           = kind;
			r.param_type     = ptype;
			r.record_length  = rlen;
			r.data_byte      = dbyte;
			r.last_in_record = lir;
			r.frame_status   = st;
			r.last           = 1'b0;
			owed_results.push_back(r);
		endfunction

		function void owe_data(bit [7:0] b, bit flast);
			rleft = rleft - 8'd1;
			owe(cidp_pkg::KIND_DATA, rtype, 8'd0, b, (rleft == 8'd0) || flast,
				cidp_pkg::ST_OK);
		endfunction

		function void parse_byte(bit c, bit [7:0] b);
			int                n0;
			bit [8:0]          p;
			bit                flast;
			logic [1:0]        st;
			cidp_pkg::result_t r;
			n0 = owed_results.size();
			if (c == cidp_pkg::CMD_RESTART) begin
				clear_frame();
				parsed++;
				return;
			end
			if (done)
				return;
			parsed++;
			sum = sum + b;
			if (pos == 9'd0) begin
				if (b == regs.single_format_code)
					mkind = cidp_pkg::MK_SINGLE;
				else if (b == regs.multi_format_code)
					mkind = cidp_pkg::MK_MULTI;
				else
					mkind = cidp_pkg::MK_UNKNOWN;
				pos = 9'd1;
			end else if (pos == 9'd1) begin
				plen = b;
				pos  = 9'd2;
			end else if (pos - 9'd2 < {1'b0, plen}) begin
				p     = pos - 9'd2;
				flast = (p + 9'd1 == {1'b0, plen});
				case (mkind)
					cidp_pkg::MK_SINGLE: begin
						if (rleft == 8'd0) begin
							if (p == 9'd0) begin
								rtype = regs.datetime_record_code;
								rleft = cidp_pkg::DATE_LEN;
							end else if (b == cidp_pkg::CHAR_P || b == cidp_pkg::CHAR_O) begin
								rtype = regs.absent_record_code;
								rleft = 8'd1;
							end else begin
								rtype = regs.number_record_code;
								rleft = plen - cidp_pkg::DATE_LEN;
							end
							owe(cidp_pkg::KIND_HEADER, rtype, rleft, 8'd0, 1'b0,
								cidp_pkg::ST_OK);
						end
						owe_data(b, flast);
					end
					cidp_pkg::MK_MULTI: begin
						case (phase)
							cidp_pkg::PH_TYPE: begin
								rtype = b;
								phase = cidp_pkg::PH_LEN;
							end
							cidp_pkg::PH_LEN: begin
								rleft = b;
								owe(cidp_pkg::KIND_HEADER, rtype, b, 8'd0, 1'b0,
									cidp_pkg::ST_OK);
								phase = (b == 8'd0) ? cidp_pkg::PH_TYPE : cidp_pkg::PH_DATA;
							end
							default: begin
								owe_data(b, flast);
								if (rleft == 8'd0)
									phase = cidp_pkg::PH_TYPE;
							end
						endcase
					end
					default: ;
				endcase
				pos = pos + 9'd1;
			end else begin
				if (mkind != cidp_pkg::MK_SINGLE && mkind != cidp_pkg::MK_MULTI)
					st = cidp_pkg::ST_BAD_TYPE;
				else
					st = (sum != 8'd0) ? cidp_pkg::ST_BAD_SUM : cidp_pkg::ST_OK;
				owe(cidp_pkg::KIND_STATUS, 8'd0, 8'd0, 8'd0, 1'b0, st);
				done = 1'b1;
			end
			if (owed_results.size() > n0) begin
				r = owed_results.pop_back();
				r.last = 1'b1;
				owed_results.push_back(r);
			end
		endfunction

		function void cmp(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			end
		endfunction

		function void match_result(cidp_pkg::result_t got);
			cidp_pkg::result_t want;
			if (owed_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual %h", $time, got);
				return;
			end
			want = owed_results.pop_front();
			matched++;
			cmp("kind", 8'(want.kind), 8'(got.kind));
			cmp("param_type", want.param_type, got.param_type);
			cmp("record_length", want.record_length, got.record_length);
			cmp("data_byte", want.data_byte, got.data_byte);
			cmp("last_in_record", 8'(want.last_in_record), 8'(got.last_in_record));
			cmp("frame_status", 8'(want.frame_status), 8'(got.frame_status));
			cmp("last", 8'(want.last), 8'(got.last));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	cidp_cfg_if cfg_bus();
	cidp_in_if  rx_bus();
	cidp_out_if res_bus();

	caller_id_frame_parser_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.rx     (rx_bus),
		.res    (res_bus)
	);

	cid_parse_tracker sb = new();
	rx_item_t         stim_q[$];
	int               cycles     = 0;
	int               hold_left  = 0;
	int               holds      = 0;
	int               rdy_mode   = 0;
	bit               gaps_on    = 1'b0;
	int               burst_left = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
		$display("DONE: errors detected");
		$finish;
	end

	// result side: check, then pick next ready
	initial begin
		cidp_pkg::result_t got;
		int                tick;
		tick = 0;
		res_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
				got.kind           = res_bus.kind;
				got.param_type     = res_bus.param_type;
				got.record_length  = res_bus.record_length;
				got.data_byte      = res_bus.data_byte;
				got.last_in_record = res_bus.last_in_record;
				got.frame_status   = res_bus.frame_status;
				got.last           = res_bus.last;
				sb.match_result(got);
			end
			tick++;
			if (hold_left > 0) begin
				hold_left--;
				res_bus.ready <= 1'b0;
			end else begin
				case (rdy_mode)
					0: res_bus.ready <= 1'b1;
					1: res_bus.ready <= ($urandom_range(0, 3) != 0);
					default: res_bus.ready <= ((tick % 13) >= 4);
				endcase
			end
		end
	end

	task automatic send_item(bit c, bit [7:0] v);
		if (gaps_on) begin
			if (burst_left == 0) begin
				rx_bus.valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				burst_left = $urandom_range(1, 30);
			end
			burst_left--;
		end
		rx_bus.valid   <= 1'b1;
		rx_bus.cmd     <= c;
		rx_bus.rx_byte <= v;
		do @(posedge clk); while (rx_bus.ready !== 1'b1);
		sb.parse_byte(c, v);
	endtask

	task automatic drain_stim();
		rx_item_t it;
		while (stim_q.size() != 0) begin
			it = stim_q.pop_front();
			send_item(it.cmd, it.val);
		end
	endtask

	task automatic settle();
		rx_bus.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(bit [cidp_pkg::CFG_IDX_W-1:0] idx, bit [7:0] v);
		cfg_bus.valid     <= 1'b1;
		cfg_bus.reg_index <= idx;
		cfg_bus.wr_data   <= v;
		do @(posedge clk); while (cfg_bus.ready !== 1'b1);
		sb.set_reg(idx, v);
	endtask

	task automatic load_setting(int ph);
		bit [7:0] v[5];
		foreach (v[i]) v[i] = 8'($urandom);
		case (ph)
			0: v = '{8'd4, 8'd128, 8'd1, 8'd2, 8'd4};
			1: v = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00};
			2: v = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF};
			3: v[1] = v[0];
			default: ;
		endcase
		write_reg(cidp_pkg::REG_SINGLE_FMT, v[0]);
		write_reg(cidp_pkg::REG_MULTI_FMT, v[1]);
		write_reg(cidp_pkg::REG_DATETIME, v[2]);
		write_reg(cidp_pkg::REG_NUMBER, v[3]);
		write_reg(cidp_pkg::REG_ABSENT, v[4]);
		write_reg(cidp_pkg::REG_ABSENT + 3'd1 + 3'($urandom_range(0, 2)), 8'($urandom));
		cfg_bus.valid <= 1'b0;
	endtask

	function automatic void push_item(bit c, bit [7:0] v);
		rx_item_t it;
		it.cmd = c;
		it.val = v;
		stim_q.push_back(it);
	endfunction

	function automatic void queue_framed(bit [7:0] fmt, bit [7:0] body[$], bit bad_sum);
		bit [7:0] s;
		s = fmt + 8'(body.size());
		foreach (body[i]) s = s + body[i];
		push_item(cidp_pkg::CMD_BYTE, fmt);
		push_item(cidp_pkg::CMD_BYTE, 8'(body.size()));
		foreach (body[i]) push_item(cidp_pkg::CMD_BYTE, body[i]);
		s = -s;
		if (bad_sum)
			s = s ^ 8'($urandom_range(1, 255));
		push_item(cidp_pkg::CMD_BYTE, s);
	endfunction

	function automatic void queue_frame();
		bit [7:0] body[$];
		bit [7:0] fmt;
		int       sel;
		int       n;
		int       n0;
		int       keep;
		sel = $urandom_range(0, 99);
		if (sel < 45) begin
			fmt = sb.regs.single_format_code;
			repeat (8) body.push_back(8'($urandom));
			case ($urandom_range(0, 9))
				0, 1: begin
					body.push_back($urandom_range(0, 1) ? cidp_pkg::CHAR_P
						: cidp_pkg::CHAR_O);
					if ($urandom_range(0, 3) == 0)
						repeat ($urandom_range(1, 4)) body.push_back(8'($urandom));
				end
				2: begin
					n = $urandom_range(0, 7);
					while (body.size() > n) void'(body.pop_back());
				end
				3: begin
					if ($urandom_range(0, 9) == 0)
						repeat (247) body.push_back(8'($urandom));
					else
						repeat ($urandom_range(1, 16)) body.push_back(8'($urandom));
				end
				default: repeat ($urandom_range(1, 16)) body.push_back(8'($urandom));
			endcase
		end else if (sel < 85) begin
			fmt = sb.regs.multi_format_code;
			repeat ($urandom_range(0, 4)) begin
				body.push_back(8'($urandom));
				if ($urandom_range(0, 15) == 0) begin
					body.push_back(8'hFF);
					repeat (3) body.push_back(8'($urandom));
				end else begin
					n = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 10);
					body.push_back(8'(n));
					repeat (n) body.push_back(8'($urandom));
				end
			end
			if (body.size() > 0 && $urandom_range(0, 4) == 0) begin
				n = $urandom_range(0, body.size() - 1);
				while (body.size() > n) void'(body.pop_back());
			end
		end else begin
			do fmt = 8'($urandom);
			while (fmt == sb.regs.single_format_code || fmt == sb.regs.multi_format_code);
			repeat ($urandom_range(0, 12)) body.push_back(8'($urandom));
		end
		n0 = stim_q.size();
		queue_framed(fmt, body, $urandom_range(0, 4) == 0);
		if ($urandom_range(0, 9) == 0) begin
			// restart mid-frame
			keep = $urandom_range(1, stim_q.size() - n0 - 1);
			while (stim_q.size() > n0 + keep) void'(stim_q.pop_back());
		end else if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 3)) push_item(cidp_pkg::CMD_BYTE, 8'($urandom));
		end
		if ($urandom_range(0, 19) == 0)
			repeat ($urandom_range(1, 6)) push_item($urandom_range(0, 7) == 0, 8'($urandom));
		push_item(cidp_pkg::CMD_RESTART, 8'($urandom));
	endfunction

	initial begin
		bit [7:0] body[$];
		int       target;
		bit       pressed;
		bit       saved_gaps;
		arst_n            = 1'b0;
		rx_bus.valid      = 1'b0;
		rx_bus.cmd        = cidp_pkg::CMD_BYTE;
		rx_bus.rx_byte    = 8'h00;
		cfg_bus.valid     = 1'b0;
		cfg_bus.reg_index = cidp_pkg::REG_SINGLE_FMT;
		cfg_bus.wr_data   = 8'h00;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// single format: date record then private marker, good sum
		body = '{8'h00, 8'hFF, 8'h12, 8'h25, 8'h13, 8'h30, 8'hA5, 8'h5A, cidp_pkg::CHAR_P};
		queue_framed(sb.regs.single_format_code, body, 1'b0);
		push_item(cidp_pkg::CMD_RESTART, 8'hFF);
		// multi format: empty record, record cut short, bad sum, byte after end
		body = '{8'hFF, 8'h00, 8'h07, 8'h05, 8'hAA};
		queue_framed(sb.regs.multi_format_code, body, 1'b1);
		push_item(cidp_pkg::CMD_BYTE, 8'h12);
		push_item(cidp_pkg::CMD_RESTART, 8'h00);
		// unknown message type, empty payload
		body.delete();
		queue_framed(8'h33, body, 1'b0);
		push_item(cidp_pkg::CMD_RESTART, 8'h5A);
		drain_stim();

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			load_setting(ph);
			gaps_on  = (ph % 2 == 1);
			rdy_mode = ph % 3;
			target   = sb.parsed + PHASE_ITEMS;
			pressed  = 1'b0;
			while (sb.parsed < target) begin
				if (!pressed && sb.parsed > target - PHASE_ITEMS / 2) begin
					// receiver holds off while items keep coming
					hold_left  = 200;
					holds++;
					saved_gaps = gaps_on;
					gaps_on    = 1'b0;
					queue_frame();
					queue_frame();
					drain_stim();
					gaps_on    = saved_gaps;
					rx_bus.valid <= 1'b0;
					@(posedge clk);
					while (sb.pending() != 0) @(posedge clk);
					pressed = 1'b1;
				end else begin
					queue_frame();
					drain_stim();
				end
			end
		end

		settle();
		$display("covered %0d parsed items and %0d checked results", sb.parsed, sb.matched);
		$display("over %0d register settings with %0d receiver hold-offs", PHASES, holds);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
